// File: hdl/itda_pkg.sv
package itda_pkg;

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift_step;
        logic digit_step;
        logic sel_sign;
    } cmd_t;

    typedef struct packed {
        logic last_shift;
        logic top_zero;
        logic one_left;
        logic negative;
    } sts_t;

endpackage

// File: hdl/itda_datapath.sv
module itda_datapath #(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  itda_pkg::cmd_t        cmd,
    output itda_pkg::sts_t        sts,
    output logic [6:0]            text_char
);

    localparam int BCD_W = NUM_DIGITS * 4;
    localparam int BC_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DL_W  = $clog2(NUM_DIGITS + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [BC_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [DL_W-1:0]       left_reg, left_next;
    logic                  neg_reg, neg_next;
    logic [3:0]            top_digit;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        left_next    = left_reg;
        neg_next     = neg_reg;
        if (cmd.load)
        begin
            neg_next     = value[VALUE_BITS-1];
            mag_next     = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            bcd_next     = '0;
            bit_cnt_next = '0;
            left_next    = DL_W'(NUM_DIGITS);
        end
        else if (cmd.shift_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = mag_reg << 1;
            bit_cnt_next = bit_cnt_reg + BC_W'(1);
        end
        else if (cmd.digit_step)
        begin
            bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
            left_next = left_reg - DL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            left_reg    <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            left_reg    <= left_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign sts.last_shift = (bit_cnt_reg == BC_W'(VALUE_BITS - 1));
    assign sts.top_zero   = (top_digit == 4'd0);
    assign sts.one_left   = (left_reg == DL_W'(1));
    assign sts.negative   = neg_reg;

    assign text_char = cmd.sel_sign ? itda_pkg::CHAR_MINUS
                                    : (itda_pkg::CHAR_ZERO + {3'd0, top_digit});

    a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.digit_step |-> left_reg != '0)
        else $error("digit step with no digits left");

endmodule

// File: hdl/itda_ctrl.sv
module itda_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic           m_tlast,
    input  itda_pkg::sts_t sts,
    output itda_pkg::cmd_t cmd
);

    itda_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itda_pkg::ST_IDLE:
                if (s_tvalid)
                    state_next = itda_pkg::ST_CONVERT;
            itda_pkg::ST_CONVERT:
                if (sts.last_shift)
                    state_next = itda_pkg::ST_SKIP;
            itda_pkg::ST_SKIP:
                if (!(sts.top_zero && !sts.one_left))
                    state_next = sts.negative ? itda_pkg::ST_SIGN : itda_pkg::ST_EMIT;
            itda_pkg::ST_SIGN:
                if (m_tready)
                    state_next = itda_pkg::ST_EMIT;
            itda_pkg::ST_EMIT:
                if (m_tready && sts.one_left)
                    state_next = itda_pkg::ST_IDLE;
            default:
                state_next = itda_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        m_tlast        = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            itda_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            itda_pkg::ST_CONVERT:
                cmd.shift_step = 1'b1;
            itda_pkg::ST_SKIP:
                cmd.digit_step = sts.top_zero && !sts.one_left;
            itda_pkg::ST_SIGN:
            begin
                m_tvalid     = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            itda_pkg::ST_EMIT:
            begin
                m_tvalid       = 1'b1;
                m_tlast        = sts.one_left;
                cmd.digit_step = m_tready;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= itda_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hdl/int_to_decimal_ascii_unit.sv
// Signed integer to decimal ASCII. Each number taken on the slave side comes
// out as one transfer per character, most significant first: a '-' for a
// negative value, then the digits without leading zeros ('0' for zero); tlast
// marks the final character. The most negative and most positive values print
// exactly. One number is handled at a time: a load, shift-and-add-3 conversion
// of all VALUE_BITS bits, a step per suppressed leading zero, then one
// character per cycle while the sink is ready.
module int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,  // value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // text_char, zero pad
    output logic                                m_tlast
);

    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

    itda_pkg::cmd_t cmd;
    itda_pkg::sts_t sts;
    logic [6:0]     text_char;

    itda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    itda_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .text_char (text_char)
    );

    assign m_tdata = {1'b0, text_char};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while output pending");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[6:0] != itda_pkg::CHAR_MINUS))
        else $error("final character is a sign");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after final transfer");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int RAND_ITEMS   = 390;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_item_t;

    typedef struct {
        logic [31:0] value;
        string       text;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // text_char, zero pad
    logic        m_tlast;

    char_item_t  text_q [$];
    char_item_t  want;
    int          error_count = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          sink_wait   = 0;
    int          sink_count  = 0;
    logic        sink_hold   = 1'b0;

    // Empty text: check against the predictor only.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{32'hFFFF_FFFF,  "-1"},
        '{32'd7,          "7"},
        '{32'd9,          "9"},
        '{-32'sd9,        "-9"},
        '{32'd10,         "10"},
        '{-32'sd10,       "-10"},
        '{32'd99,         "99"},
        '{32'd100,        "100"},
        '{-32'sd100,      "-100"},
        '{32'h7FFF_FFFF,  "2147483647"},
        '{32'h8000_0000,  "-2147483648"},
        '{32'h8000_0001,  "-2147483647"},
        '{32'h7FFF_FFFE,  ""},
        '{32'd1000000000, "1000000000"},
        '{-32'sd1000000000, "-1000000000"},
        '{32'd999999999,  "999999999"},
        '{32'h5555_5555,  ""},
        '{32'hAAAA_AAAA,  ""},
        '{32'h0000_FFFF,  ""},
        '{32'hFFFF_0000,  ""}
    };

    int_to_decimal_ascii_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic void predict_text(input logic [31:0] value);
        logic [32:0] mag;
        logic [3:0]  digit_buf [10];
        int          n;
        char_item_t  c;
        mag = {value[31], value};
        if (value[31])
        begin
            mag = ~mag + 33'd1;
            c.ch   = itda_pkg::CHAR_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        n = 0;
        do
        begin
            digit_buf[n] = 4'(mag % 33'd10);
            mag = mag / 33'd10;
            n++;
        end
        while (mag != 0);
        for (int i = n - 1; i >= 0; i--)
        begin
            c.ch   = 7'(itda_pkg::CHAR_ZERO + 7'(digit_buf[i]));
            c.last = (i == 0);
            text_q.push_back(c);
        end
    endfunction

    function automatic void queue_literal_text(input string text);
        char_item_t c;
        for (int i = 0; i < text.len(); i++)
        begin
            c.ch   = 7'(text[i]);
            c.last = (i == text.len() - 1);
            text_q.push_back(c);
        end
    endfunction

    function automatic logic [31:0] random_value();
        int unsigned pick;
        int unsigned p;
        logic [31:0] v;
        pick = $urandom_range(0, 5);
        case (pick)
            0, 1: v = $urandom;
            2: v = 32'($urandom_range(0, 200)) - 32'd100;
            3:
            begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            4: v = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                : 32'h7FFF_FFFF - $urandom_range(0, 3);
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_number(input logic [31:0] value, input string text);
        int gap;
        gap = (((items_sent / 30) % 4) == 3) ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (text.len() != 0)
            queue_literal_text(text);
        else
            predict_text(value);
        items_sent++;
    endtask

    // Sink: per-transfer random wait, quiet stretches, and the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : sink_side
        int w;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_wait  <= 0;
            sink_count <= 0;
        end
        else
        begin
            w = sink_wait;
            if (m_tvalid && m_tready)
            begin
                sink_count <= sink_count + 1;
                w = (((sink_count / 80) % 4) == 3) ? 0 : $urandom_range(0, 19);
            end
            else if (!sink_hold && w != 0)
                w = w - 1;
            sink_wait <= w;
            m_tready  <= (w == 0) && !sink_hold;
        end
    end

    initial
    begin
        wait (items_sent >= 80);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (text_q.size() == 0)
                report_mismatch($sformatf("unexpected transfer char=%0d last=%0b",
                                          m_tdata[6:0], m_tlast));
            else
            begin
                want = text_q.pop_front();
                if (m_tdata[6:0] !== want.ch)
                    report_mismatch($sformatf("text_char got %0d want %0d",
                                              m_tdata[6:0], want.ch));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_char got %0b want %0b",
                                              m_tlast, want.last));
                if (m_tdata[7] !== 1'b0)
                    report_mismatch("tdata pad bit not zero");
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_table[i])
            send_number(dir_table[i].value, dir_table[i].text);
        for (int i = 0; i < RAND_ITEMS; i++)
            send_number(random_value(), "");
        s_tvalid <= 1'b0;
        while (text_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
